// ----- rtl/uart_frame_receiver_sum16_macros.svh -----
// Assertion macros for the frame receiver checks
`ifndef UART_FRAME_RECEIVER_SUM16_MACROS_SVH
`define UART_FRAME_RECEIVER_SUM16_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define UFRS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("frame receiver check failed");

// Next-cycle implication, disabled while in reset
`define UFRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("frame receiver check failed");

`endif

// ----- rtl/ufrs_pkg.sv -----
`default_nettype none
package ufrs_pkg;

	typedef logic [1:0] status_t;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_BAD_ADDR = 2'd1;
	localparam status_t ST_BAD_SUM  = 2'd2;
	localparam status_t ST_BAD_TERM = 2'd3;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_REPORT  = 1'b1;

	localparam logic REG_START_CODE = 1'b0;
	localparam logic REG_DEV_ADDR   = 1'b1;

	localparam logic [7:0] CR_BYTE = 8'h0d;
	localparam logic [7:0] LF_BYTE = 8'h0a;

	localparam logic [7:0] START_CODE_RST = 8'h3A;
	localparam logic [7:0] DEV_ADDR_RST   = 8'h16;

endpackage
`default_nettype wire

// ----- rtl/uart_frame_receiver_sum16.sv -----
// Serial frame receiver with a 16-bit additive checksum.
// rx channel: one received byte per request (rx_valid, rx_stall, rx_byte).
// res channel: payload bytes as they arrive, and one report per frame
//   (kind, payload_byte, payload_index, command, frame_length, status, last).
// Frame: start code, address, command, length, payload, checksum low/high,
//   CR, LF. The sum covers address, command, length and payload bytes.
// A wrong address or a bad CR gives its report at once and returns to hunting.
// APB port: start_code at 0x0, device_address at 0x4; write only while idle.
// Path: a taken byte enters the input register, is decoded, and its result is
//   held in the result register that drives the res ports.
// Throughput: one byte per cycle while res_stall holds no result, set by the
//   single decode stage between the input register and the result register.
// Reset: hunting for the start code, sums and counts cleared, registers back
//   to start_code 0x3A and device_address 0x16, no result pending.
// When res_stall holds a result, the decode stage keeps one more byte in the
//   input register and rx_stall rises until the result is taken.
`default_nettype none
module uart_frame_receiver_sum16 (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rx_valid,
	output logic             rx_stall,
	input  wire logic [7:0]  rx_byte,
	output logic             res_valid,
	input  wire logic        res_stall,
	output logic             kind,
	output logic [7:0]       payload_byte,
	output logic [7:0]       payload_index,
	output logic [7:0]       command,
	output logic [7:0]       frame_length,
	output ufrs_pkg::status_t status,
	output logic             last,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	typedef enum logic [2:0] {
		PH_HUNT  = 3'd0,
		PH_ADDR  = 3'd1,
		PH_CMD   = 3'd2,
		PH_LEN   = 3'd3,
		PH_DATA  = 3'd4,
		PH_TRAIL = 3'd5
	} phase_t;

	logic [7:0]  start_code_q;
	logic [7:0]  device_address_q;

	phase_t      phase_q;
	logic [15:0] running_sum_q;
	logic [7:0]  held_command_q;
	logic [7:0]  held_length_q;
	logic [7:0]  byte_count_q;
	logic [7:0]  checksum_low_q;
	logic        sum_error_q;

	logic        rx_valid_s1;
	logic [7:0]  rx_byte_s1;

	logic              res_valid_q;
	logic              kind_q;
	logic [7:0]        payload_byte_q;
	logic [7:0]        payload_index_q;
	logic [7:0]        command_q;
	logic [7:0]        frame_length_q;
	ufrs_pkg::status_t status_q;
	logic              last_q;

	logic        advance;
	logic        fire;
	logic        cfg_write;

	phase_t      phase_d;
	logic [15:0] running_sum_d;
	logic [7:0]  held_command_d;
	logic [7:0]  held_length_d;
	logic [7:0]  byte_count_d;
	logic [7:0]  checksum_low_d;
	logic        sum_error_d;

	logic              emit;
	logic              kind_d;
	logic [7:0]        payload_byte_d;
	logic [7:0]        payload_index_d;
	logic [7:0]        command_d;
	logic [7:0]        frame_length_d;
	ufrs_pkg::status_t status_d;
	logic              last_d;

	assign advance  = !res_valid_q || !res_stall;
	assign fire     = rx_valid_s1 && advance;
	assign rx_stall = rx_valid_s1 && !advance;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			ufrs_pkg::REG_START_CODE: prdata = {24'd0, start_code_q};
			ufrs_pkg::REG_DEV_ADDR:   prdata = {24'd0, device_address_q};
			default:                  prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q     <= ufrs_pkg::START_CODE_RST;
			device_address_q <= ufrs_pkg::DEV_ADDR_RST;
		end else if (cfg_write) begin
			unique case (paddr[2])
				ufrs_pkg::REG_START_CODE: start_code_q     <= pwdata[7:0];
				ufrs_pkg::REG_DEV_ADDR:   device_address_q <= pwdata[7:0];
				default:                  ;
			endcase
		end
	end

	always_comb begin
		phase_d         = PH_HUNT;
		running_sum_d   = running_sum_q;
		held_command_d  = held_command_q;
		held_length_d   = held_length_q;
		byte_count_d    = byte_count_q;
		checksum_low_d  = checksum_low_q;
		sum_error_d     = sum_error_q;
		emit            = 1'b0;
		kind_d          = ufrs_pkg::KIND_REPORT;
		payload_byte_d  = 8'd0;
		payload_index_d = 8'd0;
		command_d       = held_command_q;
		frame_length_d  = held_length_q;
		status_d        = ufrs_pkg::ST_OK;
		last_d          = 1'b1;
		unique case (phase_q)
			PH_ADDR: begin
				if (rx_byte_s1 != device_address_q) begin
					emit           = 1'b1;
					command_d      = 8'd0;
					frame_length_d = 8'd0;
					status_d       = ufrs_pkg::ST_BAD_ADDR;
				end else begin
					running_sum_d = {8'd0, rx_byte_s1};
					phase_d       = PH_CMD;
				end
			end
			PH_CMD: begin
				held_command_d = rx_byte_s1;
				running_sum_d  = running_sum_q + {8'd0, rx_byte_s1};
				phase_d        = PH_LEN;
			end
			PH_LEN: begin
				held_length_d = rx_byte_s1;
				running_sum_d = running_sum_q + {8'd0, rx_byte_s1};
				byte_count_d  = 8'd0;
				phase_d       = (rx_byte_s1 == 8'd0) ? PH_TRAIL : PH_DATA;
			end
			PH_DATA: begin
				running_sum_d   = running_sum_q + {8'd0, rx_byte_s1};
				emit            = 1'b1;
				kind_d          = ufrs_pkg::KIND_PAYLOAD;
				payload_byte_d  = rx_byte_s1;
				payload_index_d = byte_count_q;
				last_d          = 1'b0;
				if (byte_count_q + 8'd1 == held_length_q) begin
					byte_count_d = 8'd0;
					phase_d      = PH_TRAIL;
				end else begin
					byte_count_d = byte_count_q + 8'd1;
					phase_d      = PH_DATA;
				end
			end
			PH_TRAIL: begin
				phase_d = PH_TRAIL;
				if (byte_count_q == 8'd0) begin
					checksum_low_d = rx_byte_s1;
					byte_count_d   = 8'd1;
				end else if (byte_count_q == 8'd1) begin
					sum_error_d  = running_sum_q != {rx_byte_s1, checksum_low_q};
					byte_count_d = 8'd2;
				end else if (byte_count_q == 8'd2 && rx_byte_s1 == ufrs_pkg::CR_BYTE) begin
					byte_count_d = 8'd3;
				end else begin
					emit         = 1'b1;
					phase_d      = PH_HUNT;
					byte_count_d = 8'd0;
					if (sum_error_q)
						status_d = ufrs_pkg::ST_BAD_SUM;
					else if (byte_count_q == 8'd2 || rx_byte_s1 != ufrs_pkg::LF_BYTE)
						status_d = ufrs_pkg::ST_BAD_TERM;
					else
						status_d = ufrs_pkg::ST_OK;
				end
			end
			default: begin
				phase_d = (rx_byte_s1 == start_code_q) ? PH_ADDR : PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid_s1 <= 1'b0;
		end else if (!rx_stall) begin
			rx_valid_s1 <= rx_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_valid && !rx_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_HUNT;
			running_sum_q  <= 16'd0;
			held_command_q <= 8'd0;
			held_length_q  <= 8'd0;
			byte_count_q   <= 8'd0;
			checksum_low_q <= 8'd0;
			sum_error_q    <= 1'b0;
		end else if (fire) begin
			phase_q        <= phase_d;
			running_sum_q  <= running_sum_d;
			held_command_q <= held_command_d;
			held_length_q  <= held_length_d;
			byte_count_q   <= byte_count_d;
			checksum_low_q <= checksum_low_d;
			sum_error_q    <= sum_error_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= emit;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			kind_q          <= kind_d;
			payload_byte_q  <= payload_byte_d;
			payload_index_q <= payload_index_d;
			command_q       <= command_d;
			frame_length_q  <= frame_length_d;
			status_q        <= status_d;
			last_q          <= last_d;
		end
	end

	assign res_valid     = res_valid_q;
	assign kind          = kind_q;
	assign payload_byte  = payload_byte_q;
	assign payload_index = payload_index_q;
	assign command       = command_q;
	assign frame_length  = frame_length_q;
	assign status        = status_q;
	assign last          = last_q;

endmodule
`default_nettype wire

// ----- rtl/ufrs_checker.sv -----
`default_nettype none
`include "uart_frame_receiver_sum16_macros.svh"
module ufrs_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              rx_stall,
	input wire logic              res_valid,
	input wire logic              res_stall,
	input wire logic              kind,
	input wire logic [7:0]        payload_byte,
	input wire logic [7:0]        payload_index,
	input wire logic [7:0]        command,
	input wire logic [7:0]        frame_length,
	input wire ufrs_pkg::status_t status,
	input wire logic              last
);

	`UFRS_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && res_stall, res_valid && $stable(kind) && $stable(payload_byte) && $stable(payload_index) && $stable(status))

	`UFRS_ASSERT_NOW(a_rx_stall_cause, clk, arst_n, rx_stall, res_valid && res_stall)

	`UFRS_ASSERT_NOW(a_kind_shape, clk, arst_n, res_valid, (kind == last) && (kind == ufrs_pkg::KIND_PAYLOAD ? status == ufrs_pkg::ST_OK : (payload_byte == 8'd0 && payload_index == 8'd0)))

	`UFRS_ASSERT_NOW(a_bad_addr_report, clk, arst_n, res_valid && status == ufrs_pkg::ST_BAD_ADDR, kind == ufrs_pkg::KIND_REPORT && command == 8'd0 && frame_length == 8'd0)

endmodule

bind uart_frame_receiver_sum16 ufrs_checker u_ufrs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rx_stall      (rx_stall),
	.res_valid     (res_valid),
	.res_stall     (res_stall),
	.kind          (kind),
	.payload_byte  (payload_byte),
	.payload_index (payload_index),
	.command       (command),
	.frame_length  (frame_length),
	.status        (status),
	.last          (last)
);
`default_nettype wire

// ----- test/uart_frame_receiver_sum16_test.sv -----
`timescale 1ns / 1ps
module uart_frame_receiver_sum16_test;

	localparam int CYCLE_LIMIT = 400000;
	localparam int IDLE_PCT = 27;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AFTER_RESULTS = 40;
	localparam int SETTLE_CYCLES = 10;

	typedef enum logic [2:0] {
		HUNT_START = 3'd0,
		WAIT_ADDR  = 3'd1,
		WAIT_CMD   = 3'd2,
		WAIT_LEN   = 3'd3,
		IN_PAYLOAD = 3'd4,
		IN_TRAILER = 3'd5
	} frame_phase_e;

	typedef enum int {
		FLAW_NONE,
		FLAW_ADDR,
		FLAW_SUM,
		FLAW_CR,
		FLAW_LF,
		FLAW_SUM_CR,
		FLAW_SUM_LF
	} frame_flaw_e;

	typedef struct packed {
		logic              kind;
		logic [7:0]        payload_byte;
		logic [7:0]        payload_index;
		logic [7:0]        command;
		logic [7:0]        frame_length;
		ufrs_pkg::status_t status;
		logic              last;
	} frame_result_t;

	typedef struct {
		logic [7:0] value;
		bit         drain_first;
	} link_item_t;

	logic              clk;
	logic              arst_n = 1'b0;
	logic              rx_valid = 1'b0;
	logic              rx_stall;
	logic [7:0]        rx_byte = 8'h00;
	logic              res_valid;
	logic              res_stall = 1'b0;
	logic              kind;
	logic [7:0]        payload_byte;
	logic [7:0]        payload_index;
	logic [7:0]        command;
	logic [7:0]        frame_length;
	ufrs_pkg::status_t status;
	logic              last;
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [2:0]        paddr = 3'd0;
	logic [31:0]       pwdata = 32'd0;
	logic [31:0]       prdata;
	logic              pready;

	uart_frame_receiver_sum16 dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.rx_valid      (rx_valid),
		.rx_stall      (rx_stall),
		.rx_byte       (rx_byte),
		.res_valid     (res_valid),
		.res_stall     (res_stall),
		.kind          (kind),
		.payload_byte  (payload_byte),
		.payload_index (payload_index),
		.command       (command),
		.frame_length  (frame_length),
		.status        (status),
		.last          (last),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	logic [7:0]   cfg_start = ufrs_pkg::START_CODE_RST;
	logic [7:0]   cfg_address = ufrs_pkg::DEV_ADDR_RST;
	frame_phase_e rx_phase = HUNT_START;
	logic [15:0]  frame_sum = 16'd0;
	logic [7:0]   cur_command = 8'd0;
	logic [7:0]   cur_length = 8'd0;
	logic [7:0]   frame_pos = 8'd0;
	logic [7:0]   sum_low = 8'd0;
	logic         sum_bad = 1'b0;

	frame_result_t due_results[$];
	link_item_t    link_plan[$];
	int            bytes_planned = 0;
	int            mismatches = 0;
	int            results_seen = 0;
	int            cycles = 0;
	int            hold_left = 0;
	bit            hold_done = 1'b0;
	bit            steady = 1'b0;
	bit            rx_accepted = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic void deframe_byte(input logic [7:0] b);
		frame_result_t r;
		r = '0;
		case (rx_phase)
		WAIT_ADDR: begin
			if (b != cfg_address) begin
				r.kind = ufrs_pkg::KIND_REPORT;
				r.status = ufrs_pkg::ST_BAD_ADDR;
				r.last = 1'b1;
				due_results.push_back(r);
				rx_phase = HUNT_START;
			end else begin
				frame_sum = {8'h00, b};
				rx_phase = WAIT_CMD;
			end
		end
		WAIT_CMD: begin
			cur_command = b;
			frame_sum = frame_sum + 16'(b);
			rx_phase = WAIT_LEN;
		end
		WAIT_LEN: begin
			cur_length = b;
			frame_sum = frame_sum + 16'(b);
			frame_pos = 8'd0;
			if (b == 8'd0)
				rx_phase = IN_TRAILER;
			else
				rx_phase = IN_PAYLOAD;
		end
		IN_PAYLOAD: begin
			frame_sum = frame_sum + 16'(b);
			r.kind = ufrs_pkg::KIND_PAYLOAD;
			r.payload_byte = b;
			r.payload_index = frame_pos;
			r.command = cur_command;
			r.frame_length = cur_length;
			r.status = ufrs_pkg::ST_OK;
			r.last = 1'b0;
			due_results.push_back(r);
			frame_pos = frame_pos + 8'd1;
			if (frame_pos == cur_length) begin
				frame_pos = 8'd0;
				rx_phase = IN_TRAILER;
			end
		end
		IN_TRAILER: begin
			if (frame_pos == 8'd0) begin
				sum_low = b;
				frame_pos = 8'd1;
			end else if (frame_pos == 8'd1) begin
				sum_bad = (frame_sum != {b, sum_low});
				frame_pos = 8'd2;
			end else if (frame_pos == 8'd2 && b == ufrs_pkg::CR_BYTE) begin
				frame_pos = 8'd3;
			end else begin
				r.kind = ufrs_pkg::KIND_REPORT;
				r.command = cur_command;
				r.frame_length = cur_length;
				r.last = 1'b1;
				if (sum_bad)
					r.status = ufrs_pkg::ST_BAD_SUM;
				else if (frame_pos == 8'd2 || b != ufrs_pkg::LF_BYTE)
					r.status = ufrs_pkg::ST_BAD_TERM;
				else
					r.status = ufrs_pkg::ST_OK;
				due_results.push_back(r);
				rx_phase = HUNT_START;
				frame_pos = 8'd0;
			end
		end
		default: begin
			if (b == cfg_start)
				rx_phase = WAIT_ADDR;
			else
				rx_phase = HUNT_START;
		end
		endcase
	endfunction

	always @(posedge clk) begin : monitor
		frame_result_t exp;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
		rx_accepted = arst_n && rx_valid && !rx_stall;
		if (rx_accepted)
			deframe_byte(rx_byte);
		if (arst_n && res_valid && !res_stall) begin
			results_seen++;
			if (due_results.size() == 0) begin
				$error("unexpected result: kind %0h status %0h", kind, status);
				mismatches++;
			end else begin
				exp = due_results.pop_front();
				if (kind !== exp.kind) begin
					$error("kind: expected %0h actual %0h", exp.kind, kind);
					mismatches++;
				end
				if (payload_byte !== exp.payload_byte) begin
					$error("payload_byte: expected %0h actual %0h", exp.payload_byte,
						payload_byte);
					mismatches++;
				end
				if (payload_index !== exp.payload_index) begin
					$error("payload_index: expected %0h actual %0h", exp.payload_index,
						payload_index);
					mismatches++;
				end
				if (command !== exp.command) begin
					$error("command: expected %0h actual %0h", exp.command, command);
					mismatches++;
				end
				if (frame_length !== exp.frame_length) begin
					$error("frame_length: expected %0h actual %0h", exp.frame_length,
						frame_length);
					mismatches++;
				end
				if (status !== exp.status) begin
					$error("status: expected %0h actual %0h", exp.status, status);
					mismatches++;
				end
				if (last !== exp.last) begin
					$error("last: expected %0h actual %0h", exp.last, last);
					mismatches++;
				end
			end
		end
	end

	always @(negedge clk) begin : rx_driver
		link_item_t item;
		if (!arst_n) begin
			rx_valid <= 1'b0;
		end else if (!rx_valid || rx_accepted) begin
			if (link_plan.size() != 0 &&
					!(link_plan[0].drain_first && due_results.size() != 0) &&
					(steady || $urandom_range(99) >= IDLE_PCT)) begin
				item = link_plan.pop_front();
				rx_valid <= 1'b1;
				rx_byte <= item.value;
			end else begin
				rx_valid <= 1'b0;
				rx_byte <= 8'($urandom);
			end
		end
	end

	always @(negedge clk) begin : res_receiver
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else if (!hold_done && results_seen >= HOLD_AFTER_RESULTS) begin
			// hold off long enough for the block to back up into rx_stall
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
			res_stall <= 1'b1;
		end else if (steady) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= ($urandom_range(99) < IDLE_PCT);
		end
	end

	task automatic plan_byte(input logic [7:0] v, input bit drain);
		link_item_t item;
		item.value = v;
		item.drain_first = drain;
		link_plan.push_back(item);
		bytes_planned++;
	endtask

	task automatic add_frame(input logic [7:0] cmd, input int len, input frame_flaw_e flaw,
			input int fill, input bit drain);
		logic [15:0] sum;
		logic [15:0] cks;
		logic [7:0]  b;
		plan_byte(cfg_start, drain);
		if (flaw == FLAW_ADDR) begin
			do b = 8'($urandom); while (b == cfg_address);
			plan_byte(b, 1'b0);
		end else begin
			plan_byte(cfg_address, 1'b0);
			plan_byte(cmd, 1'b0);
			plan_byte(8'(len), 1'b0);
			sum = 16'(cfg_address) + 16'(cmd) + 16'(8'(len));
			for (int i = 0; i < len; i++) begin
				b = (fill < 0) ? 8'($urandom) : 8'(fill);
				sum = sum + 16'(b);
				plan_byte(b, 1'b0);
			end
			cks = sum;
			if (flaw == FLAW_SUM || flaw == FLAW_SUM_CR || flaw == FLAW_SUM_LF)
				cks = sum ^ 16'($urandom_range(1, 65535));
			plan_byte(cks[7:0], 1'b0);
			plan_byte(cks[15:8], 1'b0);
			if (flaw == FLAW_CR || flaw == FLAW_SUM_CR) begin
				do b = 8'($urandom); while (b == ufrs_pkg::CR_BYTE);
				plan_byte(b, 1'b0);
			end else begin
				plan_byte(ufrs_pkg::CR_BYTE, 1'b0);
				if (flaw == FLAW_LF || flaw == FLAW_SUM_LF) begin
					do b = 8'($urandom); while (b == ufrs_pkg::LF_BYTE);
					plan_byte(b, 1'b0);
				end else begin
					plan_byte(ufrs_pkg::LF_BYTE, 1'b0);
				end
			end
		end
	endtask

	task automatic add_traffic(input int count);
		int goal;
		int len;
		frame_flaw_e flaw;
		goal = bytes_planned + count;
		while (bytes_planned < goal) begin
			if ($urandom_range(99) < 12) begin
				repeat ($urandom_range(1, 3)) plan_byte(8'($urandom), 1'b0);
			end else begin
				if ($urandom_range(99) < 85)
					len = $urandom_range(0, 8);
				else
					len = $urandom_range(9, 40);
				if ($urandom_range(99) < 50)
					flaw = FLAW_NONE;
				else
					flaw = frame_flaw_e'($urandom_range(1, 6));
				add_frame(8'($urandom), len, flaw, -1, $urandom_range(49) == 0);
			end
		end
	endtask

	task automatic wait_idle();
		do @(posedge clk); while (link_plan.size() != 0 || rx_valid || due_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic [7:0] val);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'($urandom), val};
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if (idx == ufrs_pkg::REG_START_CODE)
			cfg_start = val;
		else
			cfg_address = val;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[7:0] !== val) begin
			$error("prdata: expected %0h actual %0h", val, prdata[7:0]);
			mismatches++;
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_ids(input logic [7:0] start_val, input logic [7:0] addr_val);
		wait_idle();
		cfg_write(ufrs_pkg::REG_START_CODE, start_val);
		cfg_write(ufrs_pkg::REG_DEV_ADDR, addr_val);
		@(posedge clk);
	endtask

	initial begin : sequencer
		logic [7:0] shared_id;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		plan_byte(8'hFF, 1'b0);
		add_frame(8'hFF, 0, FLAW_NONE, -1, 1'b0);
		// address byte equal to the start code must not reopen a frame
		plan_byte(cfg_start, 1'b0);
		plan_byte(cfg_start, 1'b0);
		add_frame(8'h00, 1, FLAW_SUM_CR, 8'hFF, 1'b0);
		add_frame(8'h81, 0, FLAW_LF, -1, 1'b0);
		add_traffic(350);

		set_ids(8'h00, 8'hFF);
		add_traffic(250);

		set_ids(8'hFF, 8'h00);
		steady = 1'b1;
		// longest frame of 0xFF bytes; the sum stays within 16 bits
		add_frame(8'($urandom), 255, FLAW_NONE, 8'hFF, 1'b1);
		add_traffic(250);
		wait_idle();
		steady = 1'b0;

		set_ids(8'($urandom), 8'($urandom));
		add_frame(8'($urandom), 120, frame_flaw_e'($urandom_range(0, 6)), -1, 1'b1);
		add_traffic(150);

		shared_id = 8'($urandom);
		set_ids(shared_id, shared_id);
		add_traffic(200);

		wait_idle();
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/ufrs_pkg.sv
rtl/uart_frame_receiver_sum16.sv
rtl/ufrs_checker.sv
test/uart_frame_receiver_sum16_test.sv
